/* hw/rtl/hpa_pkg.sv */
// Shared types and codes for the handle-based packed array.
`timescale 1ns / 1ps

package hpa_pkg;

  // Operation codes carried in the operation field
  localparam logic [2:0] OP_ADD    = 3'd0;
  localparam logic [2:0] OP_REMOVE = 3'd1;
  localparam logic [2:0] OP_READ   = 3'd2;
  localparam logic [2:0] OP_WRITE  = 3'd3;
  localparam logic [2:0] OP_DENSE  = 3'd4;

  // Status codes returned with every result word
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_LIVE  = 2'd2,
    ST_BAD_INDEX = 2'd3
  } status_t;

  // Sequencer states, one-hot
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_RD1  = 6'b000010,
    S_RD2  = 6'b000100,
    S_RD3  = 6'b001000,
    S_WB   = 6'b010000,
    S_FIN  = 6'b100000
  } state_t;

  typedef struct packed {
    logic [2:0]  operation;
    logic [7:0]  handle;
    logic [31:0] value;
    logic [7:0]  dense_index;
  } in_word_t;

  typedef struct packed {
    logic [7:0]  result_handle;
    logic [31:0] result_value;
    status_t     status;
    logic [8:0]  live_count;
  } out_word_t;

  // Result held between the last compute state and the output register
  typedef struct packed {
    logic [7:0]  result_handle;
    logic [31:0] result_value;
    status_t     status;
  } res_t;

endpackage

/* hw/rtl/handle_packed_array_top.sv */
// Top level: packed array with stable handles, sequenced over three RAMs.
//
//   port group   dir  words                     handshake
//   in_*         in   hpa_pkg::in_word_t        in_valid / in_ready
//   out_*        out  hpa_pkg::out_word_t       out_valid / out_ready
//
// Add, dense read and unknown codes pass through RD1 and FIN; read and write
// by handle add RD2; remove adds RD3 and WB too. The remove path is longest: it
// walks handle map, slot map and value store in dependent read-then-write steps,
// and the handle map takes two writes through its single write port.
// One word is in flight at a time; a finished result may sit in the output
// register while the next word is taken. Reset is ready at once: untouched
// handle map entries are supplied by a high-water mark, not a clearing pass.
`timescale 1ns / 1ps

module handle_packed_array_top #(
  parameter int CAPACITY   = 256,
  parameter int DATA_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  hpa_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output hpa_pkg::out_word_t out_data
);

  localparam int HW = $clog2(CAPACITY);        // handle / slot address bits
  localparam int CW = $clog2(CAPACITY + 1);    // count bits, holds CAPACITY
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  // control registers
  hpa_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [CW-1:0]   free_r, free_nxt;
  logic [CW-1:0]   hwm_r, hwm_nxt;
  logic            out_valid_r, out_valid_nxt;

  // operand and working registers
  logic [2:0]            op_r, op_nxt;
  logic [HW-1:0]         hdl_r, hdl_nxt;
  logic                  hin_r, hin_nxt;
  logic [DATA_WIDTH-1:0] val_r, val_nxt;
  logic [7:0]            idx_r, idx_nxt;
  logic [CW-1:0]         slot_r, slot_nxt;
  logic                  plive_r, plive_nxt;
  hpa_pkg::res_t         res_r, res_nxt;
  hpa_pkg::out_word_t    out_r, out_nxt;

  // handle map fill tracking
  logic [HW-1:0] h2s_ra_r;
  logic          h2s_fresh_r;

  // RAM ports
  logic                  h2s_we, s2h_we, v_we;
  logic [HW-1:0]         h2s_wa, s2h_wa, v_wa;
  logic [CW-1:0]         h2s_wd;
  logic [HW-1:0]         s2h_wd;
  logic [DATA_WIDTH-1:0] v_wd;
  logic [HW-1:0]         h2s_ra, s2h_ra, v_ra;
  logic [CW-1:0]         h2s_q, h2s_rd;
  logic [HW-1:0]         s2h_q;
  logic [DATA_WIDTH-1:0] v_q;

  // input decode helpers
  logic [HW+7:0] hext_in;
  logic [HW+7:0] iext_in;
  logic [CW+7:0] idx_cmp;
  logic [CW+7:0] cnt_cmp;
  logic [CW-1:0] last_c;

  assign hext_in = (HW + 8)'(in_data.handle);
  assign iext_in = (HW + 8)'(in_data.dense_index);
  assign idx_cmp = (CW + 8)'(idx_r);
  assign cnt_cmp = (CW + 8)'(count_r);
  assign last_c  = count_r - CW'(1);

  assign in_ready  = (state_r == hpa_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Storage: handle->slot, slot->handle, dense values
  hpa_ram #(.WIDTH(CW), .DEPTH(CAPACITY)) u_h2s (
    .clk(clk), .we(h2s_we), .waddr(h2s_wa), .wdata(h2s_wd),
    .raddr(h2s_ra), .rdata(h2s_q)
  );

  hpa_ram #(.WIDTH(HW), .DEPTH(CAPACITY)) u_s2h (
    .clk(clk), .we(s2h_we), .waddr(s2h_wa), .wdata(s2h_wd),
    .raddr(s2h_ra), .rdata(s2h_q)
  );

  hpa_ram #(.WIDTH(DATA_WIDTH), .DEPTH(CAPACITY)) u_val (
    .clk(clk), .we(v_we), .waddr(v_wa), .wdata(v_wd),
    .raddr(v_ra), .rdata(v_q)
  );

  // Entries at or above the high-water mark were never written: the read path
  // supplies their reset link, address plus one, in place of the RAM data.
  always_ff @(posedge clk) begin
    h2s_ra_r    <= h2s_ra;
    h2s_fresh_r <= (CW'(h2s_ra) >= hwm_r);
  end

  assign h2s_rd = h2s_fresh_r ? (CW'(h2s_ra_r) + CW'(1)) : h2s_q;

  // Sequencer and datapath
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    free_nxt      = free_r;
    hwm_nxt       = hwm_r;
    out_valid_nxt = out_valid_r;
    op_nxt        = op_r;
    hdl_nxt       = hdl_r;
    hin_nxt       = hin_r;
    val_nxt       = val_r;
    idx_nxt       = idx_r;
    slot_nxt      = slot_r;
    plive_nxt     = plive_r;
    res_nxt       = res_r;
    out_nxt       = out_r;

    h2s_we = 1'b0;
    s2h_we = 1'b0;
    v_we   = 1'b0;
    h2s_wa = '0;
    s2h_wa = '0;
    v_wa   = '0;
    h2s_wd = '0;
    s2h_wd = '0;
    v_wd   = '0;
    h2s_ra = '0;
    s2h_ra = '0;
    v_ra   = '0;

    // result register drains independently
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      hpa_pkg::S_IDLE: begin
        // first reads go out on the accept edge
        h2s_ra = (in_data.operation == hpa_pkg::OP_ADD) ? free_r[HW-1:0]
                                                        : hext_in[HW-1:0];
        s2h_ra = iext_in[HW-1:0];
        v_ra   = iext_in[HW-1:0];
        if (in_valid) begin
          op_nxt    = in_data.operation;
          hdl_nxt   = hext_in[HW-1:0];
          hin_nxt   = (hext_in < (HW + 8)'(CAPACITY));
          val_nxt   = DATA_WIDTH'(in_data.value);
          idx_nxt   = in_data.dense_index;
          state_nxt = hpa_pkg::S_RD1;
        end
      end

      hpa_pkg::S_RD1: begin
        // slot lookups for the handle paths
        s2h_ra    = h2s_rd[HW-1:0];
        v_ra      = h2s_rd[HW-1:0];
        slot_nxt  = h2s_rd;
        plive_nxt = hin_r && (h2s_rd < count_r);
        res_nxt   = '{result_handle: '0, result_value: '0, status: hpa_pkg::ST_OK};
        state_nxt = hpa_pkg::S_FIN;
        case (op_r)
          hpa_pkg::OP_ADD: begin
            if (count_r == CAP_C || free_r >= CAP_C) begin
              res_nxt.status = hpa_pkg::ST_FULL;
            end else begin
              h2s_we    = 1'b1;
              h2s_wa    = free_r[HW-1:0];
              h2s_wd    = count_r;
              s2h_we    = 1'b1;
              s2h_wa    = count_r[HW-1:0];
              s2h_wd    = free_r[HW-1:0];
              v_we      = 1'b1;
              v_wa      = count_r[HW-1:0];
              v_wd      = '0;
              count_nxt = count_r + CW'(1);
              free_nxt  = h2s_rd;
              if (free_r == hwm_r) begin
                hwm_nxt = hwm_r + CW'(1);
              end
              res_nxt.result_handle = 8'(free_r);
            end
          end
          hpa_pkg::OP_REMOVE, hpa_pkg::OP_READ, hpa_pkg::OP_WRITE: begin
            state_nxt = hpa_pkg::S_RD2;
          end
          hpa_pkg::OP_DENSE: begin
            if (idx_cmp >= cnt_cmp) begin
              res_nxt.status = hpa_pkg::ST_BAD_INDEX;
            end else begin
              res_nxt.result_handle = 8'(s2h_q);
              res_nxt.result_value  = 32'(v_q);
            end
          end
          default: begin
          end
        endcase
      end

      hpa_pkg::S_RD2: begin
        // fetch the last entry in case this is a remove
        s2h_ra    = last_c[HW-1:0];
        v_ra      = last_c[HW-1:0];
        state_nxt = hpa_pkg::S_FIN;
        if (!(plive_r && s2h_q == hdl_r)) begin
          res_nxt.status = hpa_pkg::ST_NOT_LIVE;
        end else begin
          case (op_r)
            hpa_pkg::OP_READ: begin
              res_nxt.result_value = 32'(v_q);
            end
            hpa_pkg::OP_WRITE: begin
              v_we = 1'b1;
              v_wa = slot_r[HW-1:0];
              v_wd = val_r;
            end
            hpa_pkg::OP_REMOVE: begin
              state_nxt = hpa_pkg::S_RD3;
            end
            default: begin
            end
          endcase
        end
      end

      hpa_pkg::S_RD3: begin
        // move last entry into the gap
        v_we      = 1'b1;
        v_wa      = slot_r[HW-1:0];
        v_wd      = v_q;
        s2h_we    = 1'b1;
        s2h_wa    = slot_r[HW-1:0];
        s2h_wd    = s2h_q;
        h2s_we    = 1'b1;
        h2s_wa    = s2h_q;
        h2s_wd    = slot_r;
        state_nxt = hpa_pkg::S_WB;
      end

      hpa_pkg::S_WB: begin
        // push the freed handle; runs after the move so it wins on self-move
        h2s_we    = 1'b1;
        h2s_wa    = hdl_r;
        h2s_wd    = free_r;
        free_nxt  = CW'(hdl_r);
        count_nxt = last_c;
        state_nxt = hpa_pkg::S_FIN;
      end

      hpa_pkg::S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_nxt.result_handle = res_r.result_handle;
          out_nxt.result_value  = res_r.result_value;
          out_nxt.status        = res_r.status;
          out_nxt.live_count    = 9'(count_r);
          out_valid_nxt         = 1'b1;
          state_nxt             = hpa_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = hpa_pkg::S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= hpa_pkg::S_IDLE;
      count_r     <= '0;
      free_r      <= '0;
      hwm_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      free_r      <= free_nxt;
      hwm_r       <= hwm_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    hdl_r   <= hdl_nxt;
    hin_r   <= hin_nxt;
    val_r   <= val_nxt;
    idx_r   <= idx_nxt;
    slot_r  <= slot_nxt;
    plive_r <= plive_nxt;
    res_r   <= res_nxt;
    out_r   <= out_nxt;
  end

  // Checks
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP_C)
    else $error("live count above capacity");

  a_hwm_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= hwm_r && free_r <= hwm_r)
    else $error("high-water mark below count or free head");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> (count_r == $past(count_r) || count_r == $past(count_r) + CW'(1)
              || count_r + CW'(1) == $past(count_r)))
    else $error("live count moved by more than one");

  a_fin_load: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == hpa_pkg::S_FIN && (!out_valid_r || out_ready)
      |=> out_valid_r && state_r == hpa_pkg::S_IDLE)
    else $error("finished result not loaded");

  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("sequencer state not one-hot");

endmodule

/* hw/rtl/hpa_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module hpa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* dv/handle_packed_array_top_test.sv */
// Self-checking testbench for the handle-based packed array top level.
`timescale 1ns / 1ps

module handle_packed_array_top_test;

  localparam int CAP       = 256;
  localparam int LIMIT     = 400000;
  localparam int MAX_NOTES = 40;

  // Codes the block must ignore
  localparam logic [2:0] OP_RSVD_LO = 3'd5;
  localparam logic [2:0] OP_RSVD_HI = 3'd7;

  // Receiver stall patterns
  localparam int RX_ALWAYS = 0;
  localparam int RX_RANDOM = 1;
  localparam int RX_CYCLIC = 2;
  localparam int RX_SPARSE = 3;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  hpa_pkg::in_word_t  in_data;
  logic               out_valid;
  logic               out_ready;
  hpa_pkg::out_word_t out_data;

  handle_packed_array_top uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow copy of the handle table
  logic [8:0]  hmap   [CAP];
  logic [8:0]  smap   [CAP];
  logic [31:0] vstore [CAP];
  logic [8:0]  free_top;
  logic [8:0]  live_n;
  int          peak_live;

  hpa_pkg::out_word_t pending_results[$];
  hpa_pkg::out_word_t want_w;

  int err_count;
  int words_sent;
  int words_checked;
  int status_seen[4];

  // Stimulus knobs
  int rx_mode;
  int hold_left;
  int rx_phase;
  bit gaps_on;
  int burst_left;

  function automatic void clear_table();
    for (int i = 0; i < CAP; i++) begin
      hmap[i]   = 9'(i + 1);
      smap[i]   = '0;
      vstore[i] = '0;
    end
    free_top  = '0;
    live_n    = '0;
    peak_live = 0;
  endfunction

  // A handle is live when its slot is occupied and maps straight back
  function automatic logic handle_live(input logic [7:0] h, output logic [7:0] slot);
    slot = hmap[h][7:0];
    return (hmap[h] < live_n) && (smap[hmap[h][7:0]] == {1'b0, h});
  endfunction

  // Applies one word to the shadow table and returns the result it should give
  function automatic hpa_pkg::out_word_t table_step(input hpa_pkg::in_word_t w);
    hpa_pkg::out_word_t r;
    logic [7:0] s;
    logic [7:0] last;
    logic [8:0] moved;
    logic [7:0] nh;
    r        = '0;
    r.status = hpa_pkg::ST_OK;
    case (w.operation)
      hpa_pkg::OP_ADD: begin
        if (live_n >= CAP || free_top >= CAP) begin
          r.status = hpa_pkg::ST_FULL;
        end else begin
          nh                   = free_top[7:0];
          free_top             = hmap[nh];
          hmap[nh]             = live_n;
          smap[live_n[7:0]]    = {1'b0, nh};
          vstore[live_n[7:0]]  = '0;
          live_n               = live_n + 9'd1;
          r.result_handle      = nh;
        end
      end
      hpa_pkg::OP_REMOVE: begin
        if (!handle_live(w.handle, s)) begin
          r.status = hpa_pkg::ST_NOT_LIVE;
        end else begin
          // last word fills the gap; the freed handle goes on top of the list
          last              = 8'(live_n - 9'd1);
          moved             = smap[last];
          vstore[s]         = vstore[last];
          hmap[moved[7:0]]  = {1'b0, s};
          smap[s]           = moved;
          hmap[w.handle]    = free_top;
          free_top          = {1'b0, w.handle};
          live_n            = live_n - 9'd1;
        end
      end
      hpa_pkg::OP_READ: begin
        if (!handle_live(w.handle, s)) r.status = hpa_pkg::ST_NOT_LIVE;
        else r.result_value = vstore[s];
      end
      hpa_pkg::OP_WRITE: begin
        if (!handle_live(w.handle, s)) r.status = hpa_pkg::ST_NOT_LIVE;
        else vstore[s] = w.value;
      end
      hpa_pkg::OP_DENSE: begin
        if ({1'b0, w.dense_index} >= live_n) begin
          r.status = hpa_pkg::ST_BAD_INDEX;
        end else begin
          r.result_handle = smap[w.dense_index][7:0];
          r.result_value  = vstore[w.dense_index];
        end
      end
      default: ;
    endcase
    r.live_count = live_n;
    if (live_n > peak_live) peak_live = live_n;
    return r;
  endfunction

  function automatic hpa_pkg::in_word_t make_word(input logic [2:0] op, input logic [7:0] h,
                                                  input logic [31:0] v,
                                                  input logic [7:0] idx);
    hpa_pkg::in_word_t w;
    w.operation   = op;
    w.handle      = h;
    w.value       = v;
    w.dense_index = idx;
    return w;
  endfunction

  // Mostly live handles, some stale (top of free list), some arbitrary
  function automatic logic [7:0] pick_handle();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (live_n != 0 && r < 8) return smap[$urandom_range(0, live_n - 1)][7:0];
    if (r == 8) return free_top[7:0];
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] pick_index();
    if (live_n != 0 && $urandom_range(0, 99) < 85)
      return 8'($urandom_range(0, live_n - 1));
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    if (err_count < MAX_NOTES)
      $display("%0t: mismatch on %s: got %0h, expected %0h (result %0d)",
               $realtime, what, got, want, words_checked);
    err_count++;
  endtask

  // Sends one word; bursts of random length separated by random gaps
  task automatic send_word(input hpa_pkg::in_word_t w);
    int gap;
    if (gaps_on && burst_left == 0) begin
      gap        = $urandom_range(1, 8);
      burst_left = $urandom_range(1, 12);
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
    end
    if (burst_left > 0) burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(table_step(w));
    words_sent++;
  endtask

  // Sender pauses until every expected result has come back
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        flag_mismatch("result with nothing expected", 64'(out_data), '0);
      end else begin
        want_w = pending_results.pop_front();
        if (out_data.result_handle !== want_w.result_handle)
          flag_mismatch("result_handle", out_data.result_handle, want_w.result_handle);
        if (out_data.result_value !== want_w.result_value)
          flag_mismatch("result_value", out_data.result_value, want_w.result_value);
        if (out_data.status !== want_w.status)
          flag_mismatch("status", out_data.status, want_w.status);
        if (out_data.live_count !== want_w.live_count)
          flag_mismatch("live_count", out_data.live_count, want_w.live_count);
        status_seen[want_w.status]++;
      end
      words_checked++;
    end
  end

  // Receiver: stall pattern per mode, plus long hold-offs on request
  initial begin
    out_ready = 1'b0;
    rx_phase  = 0;
    forever begin
      @(negedge clk);
      rx_phase++;
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        case (rx_mode)
          RX_ALWAYS: out_ready <= 1'b1;
          RX_RANDOM: out_ready <= ($urandom_range(0, 9) < 7);
          RX_CYCLIC: out_ready <= ((rx_phase % 7) >= 3);
          default:   out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Watchdog
  initial begin
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: timeout with %0d results outstanding", $realtime,
             pending_results.size());
    $display("handle_packed_array_top test failed");
    $finish;
  end

  // Empty-table errors, ignored codes, add/remove ordering and LIFO reuse
  task automatic test_directed();
    rx_mode = RX_RANDOM;
    gaps_on = 1'b1;
    send_word(make_word(hpa_pkg::OP_DENSE,  8'h00, 32'h0, 8'h00));
    send_word(make_word(hpa_pkg::OP_READ,   8'h00, 32'h0, 8'h00));
    send_word(make_word(hpa_pkg::OP_REMOVE, 8'hFF, 32'h0, 8'h00));
    send_word(make_word(hpa_pkg::OP_WRITE,  8'h00, 32'hFFFF_FFFF, 8'h00));
    for (int op = OP_RSVD_LO; op <= OP_RSVD_HI; op++)
      send_word(make_word(3'(op), 8'hFF, 32'hFFFF_FFFF, 8'hFF));
    repeat (3) send_word(make_word(hpa_pkg::OP_ADD, 8'h00, 32'h0, 8'h00));
    send_word(make_word(hpa_pkg::OP_WRITE,  8'h01, 32'hFFFF_FFFF, 8'h00));
    send_word(make_word(hpa_pkg::OP_WRITE,  8'h02, 32'hA5A5_5A5A, 8'h00));
    send_word(make_word(hpa_pkg::OP_READ,   8'h01, 32'h0, 8'h00));
    send_word(make_word(hpa_pkg::OP_DENSE,  8'h00, 32'h0, 8'h01));
    send_word(make_word(hpa_pkg::OP_DENSE,  8'h00, 32'h0, 8'h02));
    send_word(make_word(hpa_pkg::OP_DENSE,  8'h00, 32'h0, 8'h03));
    // removing the first entry pulls the last one into slot 0
    send_word(make_word(hpa_pkg::OP_REMOVE, 8'h00, 32'h0, 8'h00));
    send_word(make_word(hpa_pkg::OP_READ,   8'h02, 32'h0, 8'h00));
    send_word(make_word(hpa_pkg::OP_DENSE,  8'h00, 32'h0, 8'h00));
    send_word(make_word(hpa_pkg::OP_REMOVE, 8'h00, 32'h0, 8'h00));
    send_word(make_word(hpa_pkg::OP_ADD,    8'h00, 32'h0, 8'h00));
    send_word(make_word(hpa_pkg::OP_READ,   8'h00, 32'h0, 8'h00));
    // removals that hit the last slot move an entry onto itself
    send_word(make_word(hpa_pkg::OP_REMOVE, 8'h02, 32'h0, 8'h00));
    send_word(make_word(hpa_pkg::OP_REMOVE, 8'h01, 32'h0, 8'h00));
    send_word(make_word(hpa_pkg::OP_REMOVE, 8'h00, 32'h0, 8'h00));
    wait_idle();
  endtask

  // Fill every slot, overflow, touch the top handle and index, then remove, refill and overflow again
  task automatic test_fill_and_overflow();
    rx_mode = RX_CYCLIC;
    gaps_on = 1'b1;
    while (live_n < CAP)
      send_word(make_word(hpa_pkg::OP_ADD, pick_handle(), $urandom(), pick_index()));
    repeat (2) send_word(make_word(hpa_pkg::OP_ADD, 8'h00, 32'h0, 8'h00));
    send_word(make_word(hpa_pkg::OP_DENSE, 8'h00, 32'h0, 8'hFF));
    send_word(make_word(hpa_pkg::OP_WRITE, 8'hFF, $urandom(), 8'h00));
    send_word(make_word(hpa_pkg::OP_READ,  8'hFF, 32'h0, 8'h00));
    send_word(make_word(hpa_pkg::OP_DENSE, 8'h00, 32'h0, 8'hFF));
    repeat (8) send_word(make_word(hpa_pkg::OP_REMOVE, pick_handle(), 32'h0, 8'h00));
    while (live_n < CAP)
      send_word(make_word(hpa_pkg::OP_ADD, pick_handle(), $urandom(), pick_index()));
    send_word(make_word(hpa_pkg::OP_ADD, 8'h00, 32'h0, 8'h00));
    wait_idle();
  endtask

  // Random operation mix drifting towards a target occupancy
  task automatic test_random_mix(input int n_words, input int fill_goal,
                                 input int mode, input bit gaps);
    int unsigned r;
    int unsigned add_pct;
    logic [2:0]  op;
    rx_mode = mode;
    gaps_on = gaps;
    for (int i = 0; i < n_words; i++) begin
      r       = $urandom_range(0, 99);
      add_pct = (live_n < fill_goal) ? 35 : 10;
      if (r < add_pct)      op = hpa_pkg::OP_ADD;
      else if (r < 45)      op = hpa_pkg::OP_REMOVE;
      else if (r < 65)      op = hpa_pkg::OP_READ;
      else if (r < 85)      op = hpa_pkg::OP_WRITE;
      else if (r < 97)      op = hpa_pkg::OP_DENSE;
      else                  op = 3'($urandom_range(OP_RSVD_LO, OP_RSVD_HI));
      send_word(make_word(op, pick_handle(), $urandom(), pick_index()));
    end
    wait_idle();
  endtask

  // Long receiver hold-off while the sender keeps offering back to back
  task automatic test_output_holdoff();
    rx_mode   = RX_ALWAYS;
    gaps_on   = 1'b0;
    hold_left = 300;
    for (int i = 0; i < 24; i++)
      send_word(make_word(3'($urandom_range(hpa_pkg::OP_ADD, hpa_pkg::OP_DENSE)),
                          pick_handle(), $urandom(), pick_index()));
    wait_idle();
  endtask

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    rx_mode    = RX_ALWAYS;
    hold_left  = 0;
    gaps_on    = 1'b0;
    burst_left = 0;
    err_count  = 0;
    words_sent = 0;
    words_checked = 0;
    for (int i = 0; i < 4; i++) status_seen[i] = 0;
    clear_table();

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_fill_and_overflow();
    test_random_mix(180, 8,   RX_ALWAYS, 1'b0);
    test_random_mix(200, 128, RX_RANDOM, 1'b1);
    test_random_mix(180, 250, RX_CYCLIC, 1'b1);
    test_random_mix(160, 2,   RX_SPARSE, 1'b1);
    test_output_holdoff();

    wait_idle();
    repeat (20) @(posedge clk);

    $display("run covered %0d words, %0d results checked, peak occupancy %0d",
             words_sent, words_checked, peak_live);
    $display("status mix: ok %0d, full %0d, not live %0d, bad index %0d",
             status_seen[hpa_pkg::ST_OK], status_seen[hpa_pkg::ST_FULL],
             status_seen[hpa_pkg::ST_NOT_LIVE], status_seen[hpa_pkg::ST_BAD_INDEX]);
    if (err_count == 0) begin
      $display("handle_packed_array_top test passed");
    end else begin
      $display("handle_packed_array_top test failed");
    end
    $finish;
  end

endmodule
